// ===== hw/rtl/array_unnest_row_expander_assert.svh =====
// assertion macros used by the expander datapath
// both sample on the rising edge of clock and stay quiet while reset is high
`ifndef ARRAY_UNNEST_ROW_EXPANDER_ASSERT_SVH
`define ARRAY_UNNEST_ROW_EXPANDER_ASSERT_SVH

// same-cycle implication
`define AURE_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("expander check failed");

// next-cycle implication
`define AURE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("expander check failed");

`endif

// ===== hw/rtl/aure_pkg.sv =====
package aure_pkg;

   // longest run and row number width
   localparam int MAX_LEN  = 64;
   localparam int ROW_BITS = 16;

   // fixed field widths
   localparam int ROW_W = 16;
   localparam int IDX_W = 31;
   localparam int CNT_W = 7;
   localparam int ORD_W = 7;
   localparam int BR_W  = 16;

   // run length and position widths
   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int POS_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   // mask applied to the row number
   localparam logic [ROW_W-1:0] ROW_MASK =
      (ROW_BITS >= ROW_W) ? {ROW_W{1'b1}} : ROW_W'((32'd1 << ROW_BITS) - 32'd1);

   // stream payload widths
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 88;
   localparam int REQ_USER_W = 2;
   localparam int RSP_USER_W = 4;

   // register file
   localparam int ADDR_W = 4;
   localparam int REG_W  = 32;
   localparam logic [1:0] REG_MARKER_EN = 2'd0;
   localparam logic [1:0] REG_ORD_EN    = 2'd1;
   localparam logic [1:0] REG_BATCH     = 2'd2;
   localparam logic [BR_W-1:0] BATCH_ROWS_RESET = 16'd1024;

   typedef struct packed {
      logic            marker_enable;
      logic            ordinality_enable;
      logic [BR_W-1:0] batch_rows;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic gen;
      logic sel_in;
      logic clear_fill;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_free;
      logic in_run_zero;
      logic in_final;
      logic last;
   } status_type;

   // counts above the longest run are cut to it
   function automatic logic [LEN_W-1:0] clamp_len(input logic [CNT_W-1:0] c);
      logic [LEN_W-1:0] r;
      if (c > CNT_W'(MAX_LEN)) begin
         r = LEN_W'(MAX_LEN);
      end else begin
         r = LEN_W'(c);
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/aure_csr.sv =====
module aure_csr import aure_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [REG_W-1:0]  csr_pwdata,
   output logic [REG_W-1:0]  csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   logic            marker_en_ff, marker_en_in;
   logic            ord_en_ff, ord_en_in;
   logic [BR_W-1:0] batch_rows_ff, batch_rows_in;
   logic            wr_en;
   logic [1:0]      reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[3:2];

   // write decode
   always_comb begin
      marker_en_in  = marker_en_ff;
      ord_en_in     = ord_en_ff;
      batch_rows_in = batch_rows_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_MARKER_EN: marker_en_in  = csr_pwdata[0];
            REG_ORD_EN:    ord_en_in     = csr_pwdata[0];
            REG_BATCH:     batch_rows_in = csr_pwdata[BR_W-1:0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_en_ff  <= 1'b0;
         ord_en_ff     <= 1'b0;
         batch_rows_ff <= BATCH_ROWS_RESET;
      end else begin
         marker_en_ff  <= marker_en_in;
         ord_en_ff     <= ord_en_in;
         batch_rows_ff <= batch_rows_in;
      end
   end

   // read decode
   always_comb begin
      unique case (reg_sel)
         REG_MARKER_EN: csr_prdata = REG_W'(marker_en_ff);
         REG_ORD_EN:    csr_prdata = REG_W'(ord_en_ff);
         REG_BATCH:     csr_prdata = REG_W'(batch_rows_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.marker_enable     = marker_en_ff;
   assign cfg.ordinality_enable = ord_en_ff;
   assign cfg.batch_rows        = batch_rows_ff;

endmodule

// ===== hw/rtl/aure_ctrl.sv =====
module aure_ctrl import aure_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  status_type status,
   input  logic       req_tvalid,
   output logic       req_tready,
   output cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      accept         = 1'b0;
      cmd.load       = 1'b0;
      cmd.gen        = 1'b0;
      cmd.sel_in     = 1'b0;
      cmd.clear_fill = 1'b0;
      unique case (state_ff)
         // take a row once the output slot frees up, first result goes out at once
         ST_IDLE: begin
            req_tready     = status.slot_free & ~reset;
            accept         = req_tvalid & req_tready;
            cmd.sel_in     = 1'b1;
            cmd.load       = accept;
            cmd.gen        = accept & (~status.in_run_zero | cfg.marker_enable);
            cmd.clear_fill = accept & status.in_run_zero & ~cfg.marker_enable
                             & status.in_final;
            if (accept && !status.in_run_zero && !status.last) begin
               state_in = ST_EMIT;
            end
         end
         // one result per free slot until the run is done
         ST_EMIT: begin
            cmd.gen = status.slot_free;
            if (status.slot_free && status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/aure_dpath.sv =====
`include "array_unnest_row_expander_assert.svh"

module aure_dpath import aure_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   // unpacked request beat
   logic [ROW_W-1:0] in_row;
   logic [IDX_W-1:0] in_off1, in_off2;
   logic [LEN_W-1:0] in_eff1, in_eff2, in_run;

   // held row
   logic [ROW_W-1:0] row_ff;
   logic             fin_ff;
   logic [IDX_W-1:0] off1_ff, off2_ff;
   logic [LEN_W-1:0] eff1_ff, eff2_ff, run_ff;
   logic [POS_W-1:0] pos_ff;

   // selected source for the current result
   logic [ROW_W-1:0] s_row;
   logic             s_fin;
   logic [IDX_W-1:0] s_off1, s_off2;
   logic [LEN_W-1:0] s_eff1, s_eff2, s_run, s_pos1;
   logic [POS_W-1:0] s_pos;
   logic             s_has1, s_has2, s_runz, s_last;

   // batch counter
   logic [BR_W-1:0] fill_ff, fill_in, fill_next;
   logic            batch_end;

   // output register
   logic             out_valid_ff, out_valid_in;
   logic [ROW_W-1:0] out_row_ff;
   logic [IDX_W-1:0] out_idx1_ff, out_idx2_ff;
   logic             out_null1_ff, out_null2_ff;
   logic [ORD_W-1:0] out_ord_ff;
   logic             out_marker_ff, out_be_ff, out_last_ff;

   // request fields, null channels count as empty
   assign in_row  = req_tdata[15:0] & ROW_MASK;
   assign in_off1 = req_tdata[46:16];
   assign in_off2 = req_tdata[84:54];
   assign in_eff1 = req_tuser[0] ? '0 : clamp_len(req_tdata[53:47]);
   assign in_eff2 = req_tuser[1] ? '0 : clamp_len(req_tdata[91:85]);
   assign in_run  = (in_eff2 > in_eff1) ? in_eff2 : in_eff1;

   // first result comes straight from the beat, the rest from the held row
   always_comb begin
      if (cmd.sel_in) begin
         s_row  = in_row;
         s_fin  = req_tlast;
         s_off1 = in_off1;
         s_off2 = in_off2;
         s_eff1 = in_eff1;
         s_eff2 = in_eff2;
         s_run  = in_run;
         s_pos  = '0;
      end else begin
         s_row  = row_ff;
         s_fin  = fin_ff;
         s_off1 = off1_ff;
         s_off2 = off2_ff;
         s_eff1 = eff1_ff;
         s_eff2 = eff2_ff;
         s_run  = run_ff;
         s_pos  = pos_ff;
      end
   end

   assign s_pos1 = LEN_W'(s_pos) + LEN_W'(1);
   assign s_has1 = LEN_W'(s_pos) < s_eff1;
   assign s_has2 = LEN_W'(s_pos) < s_eff2;
   assign s_runz = (s_run == '0);
   assign s_last = s_runz | (s_pos1 == s_run);

   // batch close on fill or at the end of a final row
   assign fill_next = fill_ff + BR_W'(1);
   assign batch_end = (s_last & s_fin) |
                      ((cfg.batch_rows != '0) & (fill_next >= cfg.batch_rows));

   always_comb begin
      fill_in = fill_ff;
      if (cmd.gen) begin
         fill_in = batch_end ? '0 : fill_next;
      end else if (cmd.clear_fill) begin
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // held row and position
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_ff  <= in_row;
         fin_ff  <= req_tlast;
         off1_ff <= in_off1;
         off2_ff <= in_off2;
         eff1_ff <= in_eff1;
         eff2_ff <= in_eff2;
         run_ff  <= in_run;
      end
      if (cmd.gen) begin
         pos_ff <= s_pos + POS_W'(1);
      end
   end

   // output slot
   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_tready;
      if (cmd.gen) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.gen) begin
         out_row_ff    <= s_row;
         out_idx1_ff   <= s_has1 ? s_off1 + IDX_W'(s_pos) : '0;
         out_idx2_ff   <= s_has2 ? s_off2 + IDX_W'(s_pos) : '0;
         out_null1_ff  <= ~s_has1;
         out_null2_ff  <= ~s_has2;
         out_ord_ff    <= (s_runz | ~cfg.ordinality_enable) ? '0 : ORD_W'(s_pos1);
         out_marker_ff <= ~s_runz;
         out_be_ff     <= batch_end;
         out_last_ff   <= s_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ord_ff, out_idx2_ff, out_idx1_ff, out_row_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_be_ff, out_marker_ff, out_null2_ff, out_null1_ff};

   assign status.slot_free   = ~out_valid_ff | rsp_tready;
   assign status.in_run_zero = (in_run == '0);
   assign status.in_final    = req_tlast;
   assign status.last        = s_last;

   // a result is only built into a free slot
   `AURE_ASSERT_IMPL(gen_into_free_slot, cmd.gen, !out_valid_ff || rsp_tready)
   // a held run is still inside its length
   `AURE_ASSERT_IMPL(pos_inside_run, !cmd.sel_in, LEN_W'(pos_ff) < run_ff)
   // the fill count never reaches an active batch size after a result
   `AURE_ASSERT_NEXT(fill_below_batch, cmd.gen && cfg.batch_rows != '0,
                     fill_ff < $past(cfg.batch_rows))
   // the empty-row result closes its row and carries no ordinality
   `AURE_ASSERT_IMPL(marker_shape, out_valid_ff && !out_marker_ff,
                     out_last_ff && out_ord_ff == '0 && out_null1_ff && out_null2_ff)

endmodule

// ===== hw/rtl/array_unnest_row_expander.sv =====
// Row expander for a two-channel unnest with ordinality.
// req_* takes one row descriptor per beat; rsp_* gives one result per beat,
// one for each position of the row's run (the longer non-null channel), or a
// single empty-row result when the marker is enabled and the run is empty.
// The first result of a row is registered in the cycle the row is accepted
// and shows on rsp_* in the cycle after; each further result is built once
// the output slot is free. A row holds the request channel until its last
// result is built; an empty row without marker gives none. The single output
// register sets the rate: one result per cycle while rsp_tready stays high.
// When the receiver stalls the output register holds its beat and the
// controller stops building results; req_tready drops until the slot frees.
// Reset empties the output register, returns the controller to idle, clears
// the batch counter and loads the registers with their defaults
// (marker and ordinality off, batch size 1024); req_tready stays low while
// reset is high.
// Registers: 0x0 marker enable, 0x4 ordinality enable, 0x8 batch rows.
module array_unnest_row_expander import aure_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request beat
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // row_number, first_offset, first_count, second_offset, second_count
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // final_row
   input  logic                  req_tlast,
   // first_is_null, second_is_null
   input  logic [REQ_USER_W-1:0] req_tuser,
   // result beat
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // source_row, first_index, second_index, ordinality
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // run_last
   output logic                  rsp_tlast,
   // first_null, second_null, marker, batch_end
   output logic [RSP_USER_W-1:0] rsp_tuser,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_W-1:0]     csr_paddr,
   input  logic [REG_W-1:0]      csr_pwdata,
   output logic [REG_W-1:0]      csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   aure_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   aure_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   aure_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== bench/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import aure_pkg::*;

   // cycles without any accepted beat before the run is abandoned
   localparam int STALL_LIMIT = 1000;

   typedef struct {
      logic [ROW_W-1:0] row_number;
      logic             final_row;
      logic             first_is_null;
      logic [IDX_W-1:0] first_offset;
      logic [CNT_W-1:0] first_count;
      logic             second_is_null;
      logic [IDX_W-1:0] second_offset;
      logic [CNT_W-1:0] second_count;
   } row_desc_type;

   typedef struct packed {
      logic [ROW_W-1:0] source_row;
      logic [IDX_W-1:0] first_index;
      logic             first_null;
      logic [IDX_W-1:0] second_index;
      logic             second_null;
      logic [ORD_W-1:0] ordinality;
      logic             marker;
      logic             batch_end;
      logic             run_last;
   } unnest_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]     csr_paddr = '0;
   logic [REG_W-1:0]      csr_pwdata = '0;
   logic [REG_W-1:0]      csr_prdata;
   logic                  csr_pready;

   // expected register contents and batch fill of the expander
   logic            marker_on = 1'b0;
   logic            order_on = 1'b0;
   logic [BR_W-1:0] batch_size = BATCH_ROWS_RESET;
   logic [BR_W-1:0] fill_count = '0;

   unnest_result_type pending_results[$];
   int errors = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int stall_cycles = 0;

   array_unnest_row_expander u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // advance the fill count by one result, returns the batch end flag
   function automatic logic close_batch(input logic close_now);
      logic [BR_W-1:0] next_fill;
      logic            closed;
      next_fill = fill_count + BR_W'(1);
      closed = close_now || (batch_size != '0 && next_fill >= batch_size);
      fill_count = closed ? '0 : next_fill;
      return closed;
   endfunction

   // append one expected result at the tail of the queue
   function automatic void queue_result(input unnest_result_type res);
      pending_results = {pending_results, res};
   endfunction

   // queue the results one row descriptor expands into
   function automatic void expand_row(input row_desc_type r);
      int                len1;
      int                len2;
      int                run_len;
      int                i;
      unnest_result_type res;
      len1 = (r.first_count > MAX_LEN) ? MAX_LEN : int'(r.first_count);
      len2 = (r.second_count > MAX_LEN) ? MAX_LEN : int'(r.second_count);
      run_len = 0;
      if (!r.first_is_null) run_len = len1;
      if (!r.second_is_null && len2 > run_len) run_len = len2;
      // empty row: one marker result, or nothing at all
      if (run_len == 0) begin
         if (marker_on) begin
            res = '0;
            res.source_row = r.row_number & ROW_MASK;
            res.first_null = 1'b1;
            res.second_null = 1'b1;
            res.batch_end = close_batch(r.final_row);
            res.run_last = 1'b1;
            queue_result(res);
         end else if (r.final_row) begin
            fill_count = '0;
         end
      end
      for (i = 0; i < run_len; i++) begin
         res = '0;
         res.source_row = r.row_number & ROW_MASK;
         if (!r.first_is_null && i < len1) begin
            res.first_index = r.first_offset + IDX_W'(i);
         end else begin
            res.first_null = 1'b1;
         end
         if (!r.second_is_null && i < len2) begin
            res.second_index = r.second_offset + IDX_W'(i);
         end else begin
            res.second_null = 1'b1;
         end
         res.ordinality = order_on ? ORD_W'(i + 1) : '0;
         res.marker = 1'b1;
         res.batch_end = close_batch(i == run_len - 1 && r.final_row);
         res.run_last = (i == run_len - 1);
         queue_result(res);
      end
   endfunction

   task automatic report_field(input string name, input longint want_v, input longint got_v);
      if (want_v != got_v && errors <= 20) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      end
   endtask

   // check result beats, then predict from the request beat of the same edge
   always @(posedge clock) begin : result_check
      unnest_result_type got;
      unnest_result_type want;
      row_desc_type      row;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.source_row   = rsp_tdata[15:0];
         got.first_index  = rsp_tdata[46:16];
         got.second_index = rsp_tdata[77:47];
         got.ordinality   = rsp_tdata[84:78];
         got.first_null   = rsp_tuser[0];
         got.second_null  = rsp_tuser[1];
         got.marker       = rsp_tuser[2];
         got.batch_end    = rsp_tuser[3];
         got.run_last     = rsp_tlast;
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 20) begin
               $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
            end
         end else begin
            want = pending_results.pop_front();
            if (got != want) begin
               errors++;
               report_field("source_row", want.source_row, got.source_row);
               report_field("first_index", want.first_index, got.first_index);
               report_field("first_null", want.first_null, got.first_null);
               report_field("second_index", want.second_index, got.second_index);
               report_field("second_null", want.second_null, got.second_null);
               report_field("ordinality", want.ordinality, got.ordinality);
               report_field("marker", want.marker, got.marker);
               report_field("batch_end", want.batch_end, got.batch_end);
               report_field("run_last", want.run_last, got.run_last);
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         row.row_number     = req_tdata[15:0];
         row.first_offset   = req_tdata[46:16];
         row.first_count    = req_tdata[53:47];
         row.second_offset  = req_tdata[84:54];
         row.second_count   = req_tdata[91:85];
         row.final_row      = req_tlast;
         row.first_is_null  = req_tuser[0];
         row.second_is_null = req_tuser[1];
         expand_row(row);
      end
   end

   // give up when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // one request beat, then an optional idle gap
   task automatic send_row(input row_desc_type r);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, r.second_count, r.second_offset, r.first_count, r.first_offset,
                     r.row_number};
      req_tlast  <= r.final_row;
      req_tuser  <= {r.second_is_null, r.first_is_null};
      do @(posedge clock); while (!req_tready);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // stop sending until every expected result is out and the block settles
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [REG_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_MARKER_EN: marker_on = value[0];
         REG_ORD_EN:    order_on = value[0];
         REG_BATCH:     batch_size = value[BR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_check(input logic [1:0] idx);
      logic [REG_W-1:0] want;
      case (idx)
         REG_MARKER_EN: want = REG_W'(marker_on);
         REG_ORD_EN:    want = REG_W'(order_on);
         REG_BATCH:     want = REG_W'(batch_size);
         default:       want = '0;
      endcase
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_W'({idx, 2'b00});
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         errors++;
         $display("%0t: register %0d read mismatch, expected %0h, actual %0h",
                  $time, idx, want, csr_prdata);
      end
   endtask

   task automatic csr_release();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // write all registers while idle, then read them back
   task automatic set_config(input logic marker, input logic ordinal,
                             input logic [BR_W-1:0] rows);
      wait_drained();
      csr_write(REG_MARKER_EN, REG_W'(marker));
      csr_write(REG_ORD_EN, REG_W'(ordinal));
      csr_write(REG_BATCH, REG_W'(rows));
      csr_check(REG_MARKER_EN);
      csr_check(REG_ORD_EN);
      csr_check(REG_BATCH);
      csr_release();
   endtask

   function automatic row_desc_type make_row(input logic [ROW_W-1:0] row, input logic fin,
                                             input logic null1, input logic [IDX_W-1:0] off1,
                                             input logic [CNT_W-1:0] cnt1, input logic null2,
                                             input logic [IDX_W-1:0] off2,
                                             input logic [CNT_W-1:0] cnt2);
      row_desc_type r;
      r.row_number     = row;
      r.final_row      = fin;
      r.first_is_null  = null1;
      r.first_offset   = off1;
      r.first_count    = cnt1;
      r.second_is_null = null2;
      r.second_offset  = off2;
      r.second_count   = cnt2;
      return r;
   endfunction

   // mostly short runs, some up to full length, some oversized counts
   function automatic logic [CNT_W-1:0] random_count();
      logic [CNT_W-1:0] c;
      case ($urandom_range(9)) inside
         0:       c = '0;
         [1:2]:   c = CNT_W'($urandom_range(MAX_LEN));
         3:       c = CNT_W'($urandom_range(127, MAX_LEN + 1));
         default: c = CNT_W'($urandom_range(8));
      endcase
      return c;
   endfunction

   // offsets anywhere, small, or close to the top so indexes wrap
   function automatic logic [IDX_W-1:0] random_offset();
      logic [IDX_W-1:0] o;
      case ($urandom_range(3))
         0:       o = IDX_W'($urandom_range(1000));
         1:       o = {IDX_W{1'b1}} - IDX_W'($urandom_range(70));
         default: o = IDX_W'($urandom);
      endcase
      return o;
   endfunction

   function automatic row_desc_type random_row(input logic [ROW_W-1:0] seq);
      row_desc_type r;
      r.row_number     = ($urandom_range(9) == 0) ? ROW_W'($urandom) : seq;
      r.final_row      = ($urandom_range(7) == 0);
      r.first_is_null  = ($urandom_range(4) == 0);
      r.first_offset   = random_offset();
      r.first_count    = random_count();
      r.second_is_null = ($urandom_range(4) == 0);
      r.second_offset  = random_offset();
      r.second_count   = random_count();
      return r;
   endfunction

   // reset values, then every register written and read back
   task automatic test_register_port();
      csr_check(REG_MARKER_EN);
      csr_check(REG_ORD_EN);
      csr_check(REG_BATCH);
      csr_release();
      set_config(1'b1, 1'b0, 16'hFFFF);
      set_config(1'b0, 1'b1, 16'h0000);
   endtask

   // field extremes, empty rows, index wrap, oversized counts
   task automatic test_directed_rows();
      set_config(1'b1, 1'b1, 16'd3);
      // both channels null, then zero counts: marker result each
      send_row(make_row(16'h0000, 1'b0, 1'b1, '0, '0, 1'b1, '0, '0));
      send_row(make_row(16'h0001, 1'b0, 1'b0, 31'd5, '0, 1'b0, 31'd9, '0));
      send_row(make_row(16'hFFFF, 1'b0, 1'b0, '0, 7'd1, 1'b1, 31'h7FFFFFFF, '0));
      send_row(make_row(16'h0002, 1'b0, 1'b1, 31'h7FFFFFFF, 7'h7F, 1'b0, 31'd2147483583,
                        7'd64));
      // offsets near the top wrap around
      send_row(make_row(16'h0003, 1'b0, 1'b0, 31'h7FFFFFF0, 7'd40, 1'b0, 31'h7FFFFFFF, 7'd64));
      send_row(make_row(16'h0004, 1'b0, 1'b0, 31'd100, 7'd5, 1'b0, 31'd200, 7'd3));
      send_row(make_row(16'h0005, 1'b0, 1'b0, 31'd0, 7'd3, 1'b0, 31'd7, 7'd6));
      // counts past the longest run are cut
      send_row(make_row(16'h0006, 1'b0, 1'b0, 31'h2AAAAAAA, 7'h7F, 1'b0, 31'h55555555, 7'd65));
      send_row(make_row(16'h0007, 1'b0, 1'b0, 31'd1, 7'd65, 1'b1, 31'd3, 7'd100));
      // final empty row closes the batch through its marker result
      send_row(make_row(16'h0008, 1'b1, 1'b1, '0, 7'd10, 1'b0, '0, '0));
      send_row(make_row(16'h5555, 1'b1, 1'b0, 31'h55555555, 7'd2, 1'b0, 31'h2AAAAAAA, 7'd2));
      // ordinality off reads as zero
      set_config(1'b1, 1'b0, 16'd3);
      send_row(make_row(16'hAAAA, 1'b0, 1'b0, 31'd10, 7'd4, 1'b1, '0, '0));
      send_row(make_row(16'h000A, 1'b1, 1'b1, '0, '0, 1'b1, '0, '0));
   endtask

   // batch sizes at the extremes, lowered size, silent final row
   task automatic test_batch_boundaries();
      set_config(1'b0, 1'b1, 16'd1);
      send_row(make_row(16'h0000, 1'b0, 1'b0, 31'd50, 7'd3, 1'b1, '0, '0));
      send_row(make_row(16'h0001, 1'b0, 1'b1, '0, '0, 1'b1, '0, '0));
      set_config(1'b0, 1'b1, 16'd0);
      send_row(make_row(16'h0002, 1'b0, 1'b0, 31'd0, 7'd64, 1'b0, 31'd64, 7'd64));
      send_row(make_row(16'h0003, 1'b1, 1'b0, 31'd0, 7'd64, 1'b1, '0, '0));
      send_row(make_row(16'h0000, 1'b0, 1'b0, 31'd9, 7'd20, 1'b0, 31'd1, 7'd5));
      // fill already past the new size: next result closes at once
      set_config(1'b0, 1'b1, 16'd5);
      send_row(make_row(16'h0001, 1'b0, 1'b0, 31'd7, 7'd2, 1'b0, 31'd8, 7'd2));
      send_row(make_row(16'h0002, 1'b0, 1'b0, 31'd7, 7'd6, 1'b1, '0, '0));
      // final row with no result only clears the fill
      send_row(make_row(16'h0003, 1'b1, 1'b1, '0, '0, 1'b0, '0, '0));
      send_row(make_row(16'h0000, 1'b0, 1'b1, '0, '0, 1'b0, 31'd3, 7'd5));
      set_config(1'b1, 1'b1, 16'hFFFF);
      send_row(make_row(16'h0001, 1'b0, 1'b0, 31'd1, 7'd64, 1'b0, 31'd2, 7'd30));
      send_row(make_row(16'h0002, 1'b1, 1'b1, '0, '0, 1'b1, '0, '0));
   endtask

   // random rows in runs of row numbers, one idling pattern per phase
   task automatic test_random_rows();
      int               phase;
      int               n;
      logic [ROW_W-1:0] row_seq;
      row_desc_type     r;
      row_seq = '0;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               set_config(1'b1, 1'b1, BR_W'($urandom_range(16, 1)));
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               set_config(1'b0, 1'b1, 16'd0);
               send_idle_pct = 74;
               stall_pct = 0;
            end
            2: begin
               set_config(1'b1, 1'b0, 16'hFFFF);
               send_idle_pct = 0;
               stall_pct = 74;
            end
            default: begin
               set_config(1'($urandom_range(1)), 1'b1, BR_W'($urandom_range(40, 2)));
               send_idle_pct = 27;
               stall_pct = 27;
            end
         endcase
         for (n = 0; n < 82; n++) begin
            // hold the sender back until everything has come out
            if (phase == 1 && n == 41) wait_drained();
            r = random_row(row_seq);
            row_seq = r.final_row ? '0 : row_seq + 1'b1;
            send_row(r);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_register_port();
      test_directed_rows();
      test_batch_boundaries();
      test_random_rows();
      wait_drained();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
